// ----- src/sbls_pkg.sv -----
// types, constants and gain table shared by the spectrum bar level smoother
package sbls_pkg;

   localparam int unsigned BIN_W    = 4;
   localparam int unsigned MAG_W    = 8;
   localparam int unsigned GAIN_W   = 8;
   localparam int unsigned PROD_W   = 16;
   localparam int unsigned LEVEL_W  = 7;
   localparam int unsigned HEIGHT_W = 8;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_IDLE   = 1'b1;

   localparam logic [LEVEL_W-1:0]  IDLE_LEVEL = 7'd6;
   localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = 7'd100;
   localparam logic [LEVEL_W-1:0]  KNEE       = 7'd40;
   localparam logic [HEIGHT_W-1:0] MIN_H      = 8'd8;
   localparam logic [HEIGHT_W-1:0] IDLE_H     = 8'd24;
   localparam logic [HEIGHT_W-1:0] SPAN_H     = 8'd130;

   // reciprocal multipliers, exact over the value ranges seen here
   localparam logic [12:0] DIV100_MUL = 13'd5243;  // >> 19
   localparam logic [7:0]  DIV5_MUL   = 8'd205;    // >> 10
   localparam logic [11:0] DIV7_MUL   = 12'd2341;  // >> 14
   localparam logic [9:0]  DIV11_MUL  = 10'd745;   // >> 13

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_IDLE   = 2'd1,
      KIND_NONE   = 2'd2
   } kind_type;

   typedef struct packed {
      logic               op;
      logic [BIN_W-1:0]   bin_index;
      logic [MAG_W-1:0]   magnitude;
   } req_type;

   typedef struct packed {
      logic [BIN_W-1:0]    bin_out;
      logic [LEVEL_W-1:0]  level;
      logic [HEIGHT_W-1:0] bar_height;
   } rsp_type;

   typedef struct packed {
      kind_type         kind;
      logic [BIN_W-1:0] bin;
   } tag_type;

   typedef struct packed {
      logic load_prod;
      logic load_scaled;
      logic load_target;
      logic load_level;
      logic load_out;
   } pipe_ctl_type;

   function automatic logic [GAIN_W-1:0] eq_gain(input logic [BIN_W-1:0] bin);
      logic [GAIN_W-1:0] g;
      unique case (bin)
         4'd0:  g = 8'd150;
         4'd1:  g = 8'd145;
         4'd2:  g = 8'd138;
         4'd3:  g = 8'd132;
         4'd4:  g = 8'd126;
         4'd5:  g = 8'd120;
         4'd6:  g = 8'd114;
         4'd7:  g = 8'd108;
         4'd8:  g = 8'd104;
         4'd9:  g = 8'd100;
         4'd10: g = 8'd96;
         4'd11: g = 8'd92;
         4'd12: g = 8'd88;
         4'd13: g = 8'd84;
         4'd14: g = 8'd80;
         4'd15: g = 8'd76;
      endcase
      return g;
   endfunction

endpackage

// ----- src/sbls_target.sv -----
// target path: equalizer product, scale by 1/100 with clamp, piecewise boost
module sbls_target #(
   parameter int NUM_BINS = 16
) (
   input  logic                           clock,
   input  sbls_pkg::pipe_ctl_type         ctl,
   input  sbls_pkg::req_type              req_word,
   output sbls_pkg::tag_type              target_tag,
   output logic [sbls_pkg::LEVEL_W-1:0]   target
);

   sbls_pkg::tag_type                    prod_tag_ff, prod_tag_in;
   logic [sbls_pkg::PROD_W-1:0]          prod_ff, prod_in;
   sbls_pkg::tag_type                    scaled_tag_ff;
   logic [sbls_pkg::LEVEL_W-1:0]         scaled_ff, scaled_in;
   sbls_pkg::tag_type                    target_tag_ff;
   logic [sbls_pkg::LEVEL_W-1:0]         target_ff, target_in;

   logic [28:0]                          recip_prod;
   logic [8:0]                           quot;
   logic                                 below_knee;
   logic [8:0]                           boost_num;
   logic [16:0]                          boost_prod;
   logic [7:0]                           boosted;

   // classify the word and form magnitude times gain
   always_comb begin
      prod_tag_in.bin = req_word.bin_index;
      if (req_word.op == sbls_pkg::OP_IDLE) begin
         prod_tag_in.kind = sbls_pkg::KIND_IDLE;
      end else if ({3'b000, req_word.bin_index} < 7'(NUM_BINS)) begin
         prod_tag_in.kind = sbls_pkg::KIND_SAMPLE;
      end else begin
         prod_tag_in.kind = sbls_pkg::KIND_NONE;
      end
      prod_in = 16'(req_word.magnitude) * 16'(sbls_pkg::eq_gain(req_word.bin_index));
   end

   // divide by 100, clamp to full scale
   always_comb begin
      recip_prod = 29'(prod_ff) * 29'(sbls_pkg::DIV100_MUL);
      quot       = recip_prod[27:19];
      if (quot > 9'(sbls_pkg::LEVEL_MAX)) begin
         scaled_in = sbls_pkg::LEVEL_MAX;
      end else begin
         scaled_in = quot[6:0];
      end
   end

   // 9/5 below the knee, knee plus 7/5 of the excess above it
   always_comb begin
      below_knee = scaled_ff < sbls_pkg::KNEE;
      if (below_knee) begin
         boost_num = 9'(scaled_ff) * 9'd9;
      end else begin
         boost_num = 9'(scaled_ff - sbls_pkg::KNEE) * 9'd7;
      end
      boost_prod = 17'(boost_num) * 17'(sbls_pkg::DIV5_MUL);
      if (below_knee) begin
         boosted = {1'b0, boost_prod[16:10]};
      end else begin
         boosted = {1'b0, boost_prod[16:10]} + 8'(sbls_pkg::KNEE);
      end
      if (boosted > 8'(sbls_pkg::LEVEL_MAX)) begin
         target_in = sbls_pkg::LEVEL_MAX;
      end else begin
         target_in = boosted[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         prod_tag_ff <= prod_tag_in;
         prod_ff     <= prod_in;
      end
      if (ctl.load_scaled) begin
         scaled_tag_ff <= prod_tag_ff;
         scaled_ff     <= scaled_in;
      end
      if (ctl.load_target) begin
         target_tag_ff <= scaled_tag_ff;
         target_ff     <= target_in;
      end
   end

   assign target_tag = target_tag_ff;
   assign target     = target_ff;

endmodule

// ----- src/sbls_level.sv -----
// per-bin level store and asymmetric smoothing toward the target
module sbls_level #(
   parameter int NUM_BINS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sbls_pkg::pipe_ctl_type         ctl,
   input  sbls_pkg::tag_type              target_tag,
   input  logic [sbls_pkg::LEVEL_W-1:0]   target,
   output sbls_pkg::tag_type              level_tag,
   output logic [sbls_pkg::LEVEL_W-1:0]   level
);

   // only bins a 4-bit index can reach are stored
   localparam int STORE_DEPTH = (NUM_BINS < 16) ? NUM_BINS : 16;
   localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic [sbls_pkg::LEVEL_W-1:0] store_ff [STORE_DEPTH];
   sbls_pkg::tag_type            level_tag_ff;
   logic [sbls_pkg::LEVEL_W-1:0] level_ff, level_in;

   logic [IDX_W-1:0]             idx;
   logic [sbls_pkg::LEVEL_W-1:0] cur;
   logic                         rising;
   logic [9:0]                   num;
   logic [16:0]                  rise_prod;
   logic [20:0]                  fall_prod;
   logic [sbls_pkg::LEVEL_W-1:0] smoothed;

   assign idx = target_tag.bin[IDX_W-1:0];

   always_comb begin
      cur    = store_ff[idx];
      rising = target >= cur;
      if (rising) begin
         num = 10'(cur) + {1'b0, target, 2'b00};
      end else begin
         num = 10'(cur) * 10'd6 + 10'(target);
      end
      rise_prod = 17'(num) * 17'(sbls_pkg::DIV5_MUL);
      fall_prod = 21'(num) * 21'(sbls_pkg::DIV7_MUL);
      smoothed  = rising ? rise_prod[16:10] : fall_prod[20:14];
      unique case (target_tag.kind)
         sbls_pkg::KIND_SAMPLE: level_in = smoothed;
         sbls_pkg::KIND_IDLE:   level_in = sbls_pkg::IDLE_LEVEL;
         default:               level_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= sbls_pkg::IDLE_LEVEL;
         end
      end else if (ctl.load_level) begin
         if (target_tag.kind == sbls_pkg::KIND_IDLE) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
               store_ff[i] <= sbls_pkg::IDLE_LEVEL;
            end
         end else if (target_tag.kind == sbls_pkg::KIND_SAMPLE) begin
            store_ff[idx] <= smoothed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_level) begin
         level_tag_ff <= target_tag;
         level_ff     <= level_in;
      end
   end

   assign level_tag = level_tag_ff;
   assign level     = level_ff;

endmodule

// ----- src/sbls_height.sv -----
// bar height from level and the result register
module sbls_height (
   input  logic                           clock,
   input  sbls_pkg::pipe_ctl_type         ctl,
   input  sbls_pkg::tag_type              level_tag,
   input  logic [sbls_pkg::LEVEL_W-1:0]   level,
   output sbls_pkg::rsp_type              rsp_word
);

   sbls_pkg::rsp_type rsp_ff, rsp_in;

   logic [10:0]                   scaled13;
   logic [19:0]                   div_prod;
   logic [sbls_pkg::HEIGHT_W-1:0] height;

   // 8 + level*130/110, done as 13/11
   always_comb begin
      scaled13 = 11'(level) * 11'd13;
      div_prod = 20'(scaled13) * 20'(sbls_pkg::DIV11_MUL);
      height   = sbls_pkg::MIN_H + {1'b0, div_prod[19:13]};
      if (height > sbls_pkg::SPAN_H) begin
         height = sbls_pkg::SPAN_H;
      end
      rsp_in.bin_out = level_tag.bin;
      rsp_in.level   = level;
      unique case (level_tag.kind)
         sbls_pkg::KIND_SAMPLE: rsp_in.bar_height = height;
         sbls_pkg::KIND_IDLE:   rsp_in.bar_height = sbls_pkg::IDLE_H;
         default:               rsp_in.bar_height = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

// ----- src/spectrum_bar_level_smoother.sv -----
// spectrum bar level smoother: top level with pipeline flow control
//
//  port group   dir   handshake              word
//  req_         in    req_valid/req_ready    req_data  (op, bin_index, magnitude)
//  rsp_         out   rsp_valid/rsp_ready    rsp_data  (bin_out, level, bar_height)
//
// one word per clock sustained while rsp_ready stays high; rsp_valid rises once a word
// has passed the input register, then product, scale, target, level and result registers.
// the level store is read and written in the level stage only, so back-to-back
// words on the same bin see each other's update with no bubble.
// reset clears all valid bits and sets every bin level to 6.
// each stage moves when the next one is empty or moving, so a stalled result
// lets upstream bubbles close before req_ready drops.
module spectrum_bar_level_smoother #(
   parameter int NUM_BINS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sbls_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sbls_pkg::rsp_type   rsp_data
);

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic v4_ff, v4_in, v5_ff, v5_in, vo_ff, vo_in;
   logic adv1, adv2, adv3, adv4, adv5;
   logic accept;

   sbls_pkg::req_type            req_ff;
   sbls_pkg::pipe_ctl_type       ctl;
   sbls_pkg::tag_type            target_tag;
   logic [sbls_pkg::LEVEL_W-1:0] target;
   sbls_pkg::tag_type            level_tag;
   logic [sbls_pkg::LEVEL_W-1:0] level;

   always_comb begin
      adv5      = v5_ff && (!vo_ff || rsp_ready);
      adv4      = v4_ff && (!v5_ff || adv5);
      adv3      = v3_ff && (!v4_ff || adv4);
      adv2      = v2_ff && (!v3_ff || adv3);
      adv1      = v1_ff && (!v2_ff || adv2);
      req_ready = !v1_ff || adv1;
      accept    = req_valid && req_ready;

      v1_in = accept || (v1_ff && !adv1);
      v2_in = adv1   || (v2_ff && !adv2);
      v3_in = adv2   || (v3_ff && !adv3);
      v4_in = adv3   || (v4_ff && !adv4);
      v5_in = adv4   || (v5_ff && !adv5);
      vo_in = adv5   || (vo_ff && !rsp_ready);

      ctl.load_prod   = adv1;
      ctl.load_scaled = adv2;
      ctl.load_target = adv3;
      ctl.load_level  = adv4;
      ctl.load_out    = adv5;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   sbls_target #(
      .NUM_BINS (NUM_BINS)
   ) u_target (
      .clock      (clock),
      .ctl        (ctl),
      .req_word   (req_ff),
      .target_tag (target_tag),
      .target     (target)
   );

   sbls_level #(
      .NUM_BINS (NUM_BINS)
   ) u_level (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .target_tag (target_tag),
      .target     (target),
      .level_tag  (level_tag),
      .level      (level)
   );

   sbls_height u_height (
      .clock     (clock),
      .ctl       (ctl),
      .level_tag (level_tag),
      .level     (level),
      .rsp_word  (rsp_data)
   );

   assign rsp_valid = vo_ff;

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the spectrum bar level smoother
`timescale 1ns / 100ps

class bar_level_tracker;
   localparam int unsigned BIN_COUNT    = 16;
   localparam logic [sbls_pkg::LEVEL_W-1:0]  REST_LEVEL  = 7'd6;
   localparam logic [sbls_pkg::HEIGHT_W-1:0] REST_HEIGHT = 8'd24;
   localparam int unsigned LEVEL_CEIL   = 100;
   localparam int unsigned KNEE_POINT   = 40;
   localparam int unsigned BASE_HEIGHT  = 8;
   localparam int unsigned HEIGHT_CEIL  = 130;
   localparam int unsigned HEIGHT_SCALE = 110;
   // per-bin equalizer gain in percent, bin 15 first
   localparam logic [15:0][7:0] EQ_GAIN = {
      8'd76, 8'd80, 8'd84, 8'd88, 8'd92, 8'd96, 8'd100, 8'd104,
      8'd108, 8'd114, 8'd120, 8'd126, 8'd132, 8'd138, 8'd145, 8'd150
   };

   sbls_pkg::rsp_type expected_bars[$];
   logic [sbls_pkg::LEVEL_W-1:0] bin_levels[BIN_COUNT];
   int unsigned mismatch_count;

   function new();
      mismatch_count = 0;
      foreach (bin_levels[i]) bin_levels[i] = REST_LEVEL;
   endfunction

   function sbls_pkg::rsp_type predict_bar(sbls_pkg::req_type w);
      sbls_pkg::rsp_type r;
      int unsigned tgt;
      int unsigned lvl;
      int unsigned hgt;
      r.bin_out = w.bin_index;
      if (w.op == sbls_pkg::OP_IDLE) begin
         foreach (bin_levels[i]) bin_levels[i] = REST_LEVEL;
         r.level = REST_LEVEL;
         r.bar_height = REST_HEIGHT;
         return r;
      end
      // bins past the store give an empty bar and leave the levels alone
      if (int'(w.bin_index) >= BIN_COUNT) begin
         r.level = '0;
         r.bar_height = '0;
         return r;
      end
      tgt = (int'(w.magnitude) * int'(EQ_GAIN[w.bin_index])) / 100;
      if (tgt > LEVEL_CEIL) tgt = LEVEL_CEIL;
      if (tgt < KNEE_POINT) tgt = (tgt * 18) / 10;
      else tgt = KNEE_POINT + ((tgt - KNEE_POINT) * 14) / 10;
      if (tgt > LEVEL_CEIL) tgt = LEVEL_CEIL;
      // fast attack, slow release
      lvl = int'(bin_levels[w.bin_index]);
      if (tgt >= lvl) lvl = (lvl + tgt * 4) / 5;
      else lvl = (lvl * 6 + tgt) / 7;
      bin_levels[w.bin_index] = 7'(lvl);
      hgt = BASE_HEIGHT + (lvl * HEIGHT_CEIL) / HEIGHT_SCALE;
      if (hgt > HEIGHT_CEIL) hgt = HEIGHT_CEIL;
      r.level = 7'(lvl);
      r.bar_height = 8'(hgt);
      return r;
   endfunction

   function void note_word(sbls_pkg::req_type w);
      expected_bars.push_back(predict_bar(w));
   endfunction

   function void check_word(sbls_pkg::rsp_type got);
      sbls_pkg::rsp_type want;
      if (expected_bars.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result word: bin %0d level %0d height %0d",
                     got.bin_out, got.level, got.bar_height);
         return;
      end
      want = expected_bars.pop_front();
      if (got.bin_out != want.bin_out || got.level != want.level ||
          got.bar_height != want.bar_height) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display({"mismatch at %0t: expected bin %0d level %0d height %0d,",
                      " got bin %0d level %0d height %0d"},
                     $time, want.bin_out, want.level, want.bar_height,
                     got.bin_out, got.level, got.bar_height);
      end
   endfunction

   function int pending();
      return expected_bars.size();
   endfunction
endclass

module testbench;
   localparam int NUM_BINS = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PER_PHASE = 225;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   sbls_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   sbls_pkg::rsp_type rsp_data;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycle_count = 0;
   logic [3:0] last_bin = 4'd0;

   bar_level_tracker tracker = new();

   spectrum_bar_level_smoother #(.NUM_BINS(NUM_BINS)) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (!reset) rsp_ready = ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_word(rsp_data);
   end

   // entered and left at a falling edge
   task automatic send_word(input logic op, input logic [3:0] bin, input logic [7:0] mag);
      sbls_pkg::req_type w;
      w.op = op;
      w.bin_index = bin;
      w.magnitude = mag;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = w;
      do @(posedge clock); while (!req_ready);
      tracker.note_word(w);
      @(negedge clock);
   endtask

   task automatic send_random_word();
      logic [3:0] bin;
      logic [7:0] mag;
      // revisit the same bin often so levels climb to the ceiling and decay
      bin = ($urandom_range(2) == 0) ? last_bin : 4'($urandom_range(15));
      last_bin = bin;
      case ($urandom_range(3))
         0: mag = 8'($urandom_range(255));
         1: mag = 8'($urandom_range(255, 200));
         2: mag = 8'($urandom_range(60));
         default: mag = 8'd0;
      endcase
      if ($urandom_range(19) == 0) send_word(sbls_pkg::OP_IDLE, bin, 8'($urandom_range(255)));
      else send_word(sbls_pkg::OP_SAMPLE, bin, mag);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: idle, extremes, knee, rise and fall on the edge bins
      send_word(sbls_pkg::OP_IDLE, 4'd0, 8'd0);
      send_word(sbls_pkg::OP_SAMPLE, 4'd0, 8'd255);
      send_word(sbls_pkg::OP_SAMPLE, 4'd0, 8'd255);
      send_word(sbls_pkg::OP_SAMPLE, 4'd0, 8'd255);
      send_word(sbls_pkg::OP_SAMPLE, 4'd0, 8'd0);
      send_word(sbls_pkg::OP_SAMPLE, 4'd15, 8'd255);
      send_word(sbls_pkg::OP_SAMPLE, 4'd15, 8'd0);
      send_word(sbls_pkg::OP_SAMPLE, 4'd9, 8'd40);
      send_word(sbls_pkg::OP_SAMPLE, 4'd9, 8'd39);
      send_word(sbls_pkg::OP_SAMPLE, 4'd9, 8'd41);
      send_word(sbls_pkg::OP_SAMPLE, 4'd5, 8'd170);
      send_word(sbls_pkg::OP_SAMPLE, 4'd10, 8'd85);
      send_word(sbls_pkg::OP_SAMPLE, 4'd7, 8'd1);
      send_word(sbls_pkg::OP_IDLE, 4'd15, 8'd255);
      send_word(sbls_pkg::OP_SAMPLE, 4'd0, 8'd128);
      send_word(sbls_pkg::OP_SAMPLE, 4'd3, 8'd170);
      send_word(sbls_pkg::OP_SAMPLE, 4'd12, 8'd85);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_word();
      end
      req_valid = 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (tracker.mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
